[hdl/bsc_pkg.sv]
// Shared types and constants for the bitmap set/clear/scan block.
// No dependencies; imported by every module of the block.
package bsc_pkg;

	localparam int WORD_BITS    = 64;
	localparam int WORD_LSB     = 6;
	localparam int CNT_W        = 11;
	localparam int IDX_W        = 10;
	localparam int MAX_BITS_DEF = 1024;

	localparam logic [CNT_W-1:0] BIT_COUNT_RST = 11'd1024;
	localparam logic [CNT_W-1:0] NONE_IDX      = 11'h7FF;

	// request codes; the unused codes behave as a test
	localparam logic [1:0] REQ_SET   = 2'd0;
	localparam logic [1:0] REQ_CLEAR = 2'd1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                clr;
		logic                en;
		logic                last;
		logic [WORD_LSB-1:0] rem;
	} scan_ctrl_t;

endpackage

[hdl/bsc_word_ram.sv]
// Word store of the bitmap: one write port, one read port, registered read.
// Depends on bsc_pkg.
module bsc_word_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [AW-1:0]                  wr_addr,
	input  logic [bsc_pkg::WORD_BITS-1:0]  wr_data,
	input  logic [AW-1:0]                  rd_addr,
	output logic [bsc_pkg::WORD_BITS-1:0]  rd_data
);
	import bsc_pkg::*;

	logic [WORD_BITS-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

[hdl/bsc_scan_unit.sv]
// Shared scan unit: one word per cycle, keeps lowest/highest set and unset indices.
// Depends on bsc_pkg.
module bsc_scan_unit #(
	parameter int AW = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bsc_pkg::scan_ctrl_t            ctrl,
	input  logic [bsc_pkg::WORD_BITS-1:0]  word,
	input  logic [AW-1:0]                  word_idx,
	output logic [bsc_pkg::CNT_W-1:0]      lo_set,
	output logic [bsc_pkg::CNT_W-1:0]      hi_set,
	output logic [bsc_pkg::CNT_W-1:0]      lo_unset,
	output logic [bsc_pkg::CNT_W-1:0]      hi_unset
);
	import bsc_pkg::*;

	function automatic logic [WORD_LSB-1:0] find_lo(input logic [WORD_BITS-1:0] v);
		logic [WORD_LSB-1:0] r;
		r = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) r = WORD_LSB'(i);
		end
		return r;
	endfunction

	function automatic logic [WORD_LSB-1:0] find_hi(input logic [WORD_BITS-1:0] v);
		logic [WORD_LSB-1:0] r;
		r = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (v[i]) r = WORD_LSB'(i);
		end
		return r;
	endfunction

	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] set_bits;
	logic [WORD_BITS-1:0] unset_bits;
	logic                 got_set_q;
	logic                 got_unset_q;
	logic [CNT_W-1:0]     lo_set_q;
	logic [CNT_W-1:0]     hi_set_q;
	logic [CNT_W-1:0]     lo_unset_q;
	logic [CNT_W-1:0]     hi_unset_q;

	// only bits below the bit count take part in the final word
	always_comb begin
		if (ctrl.last && (ctrl.rem != '0)) begin
			mask = ~({WORD_BITS{1'b1}} << ctrl.rem);
		end else begin
			mask = {WORD_BITS{1'b1}};
		end
		set_bits   = word & mask;
		unset_bits = ~word & mask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			got_set_q   <= 1'b0;
			got_unset_q <= 1'b0;
			lo_set_q    <= NONE_IDX;
			hi_set_q    <= NONE_IDX;
			lo_unset_q  <= NONE_IDX;
			hi_unset_q  <= NONE_IDX;
		end else if (ctrl.clr) begin
			got_set_q   <= 1'b0;
			got_unset_q <= 1'b0;
			lo_set_q    <= NONE_IDX;
			hi_set_q    <= NONE_IDX;
			lo_unset_q  <= NONE_IDX;
			hi_unset_q  <= NONE_IDX;
		end else if (ctrl.en) begin
			if (set_bits != '0) begin
				if (!got_set_q) begin
					lo_set_q <= CNT_W'({word_idx, find_lo(set_bits)});
				end
				got_set_q <= 1'b1;
				hi_set_q  <= CNT_W'({word_idx, find_hi(set_bits)});
			end
			if (unset_bits != '0) begin
				if (!got_unset_q) begin
					lo_unset_q <= CNT_W'({word_idx, find_lo(unset_bits)});
				end
				got_unset_q <= 1'b1;
				hi_unset_q  <= CNT_W'({word_idx, find_hi(unset_bits)});
			end
		end
	end

	assign lo_set   = lo_set_q;
	assign hi_set   = hi_set_q;
	assign lo_unset = lo_unset_q;
	assign hi_unset = hi_unset_q;

endmodule

[hdl/bitmap_set_clear_scan.sv]
// Bitmap set/clear/scan block, top level: sequencer, counters and result registers.
// Depends on bsc_pkg, bsc_word_ram and bsc_scan_unit.
// An accepted request passes ST_UPDATE, ST_SCAN over words 0 to ceil(n/64)-1, ST_DRAIN
// and ST_DONE (ST_UPDATE to ST_DONE when n is 0), n = min(bit_count, MAX_BITS);
// busy drops the cycle after done; the walk of the word store reads one word per cycle.
// Reset and every bit_count write start a clearing pass over all words, busy high.
// Results are shown for one cycle on done; the receiver cannot stall.
module bitmap_set_clear_scan #(
	parameter int MAX_BITS = bsc_pkg::MAX_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [bsc_pkg::CNT_W-1:0]          cfg_wr_data,
	input  logic                               start,
	input  logic [1:0]                         req_type,
	input  logic [bsc_pkg::IDX_W-1:0]          bit_index,
	output logic                               busy,
	output logic                               done,
	output logic                               previous_bit,
	output logic                               index_error,
	output logic [bsc_pkg::CNT_W-1:0]          ones_count,
	output logic                               all_zero,
	output logic                               all_one,
	output logic signed [bsc_pkg::CNT_W-1:0]   smallest_set,
	output logic signed [bsc_pkg::CNT_W-1:0]   biggest_set,
	output logic signed [bsc_pkg::CNT_W-1:0]   smallest_unset,
	output logic signed [bsc_pkg::CNT_W-1:0]   biggest_unset
);
	import bsc_pkg::*;

	localparam int WORD_COUNT = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

	state_t               state_q, state_d;

	// configuration and running count
	logic [CNT_W-1:0]     bit_count_q;
	logic [CNT_W-1:0]     set_total_q;

	// request held for the whole sequence
	logic [1:0]           req_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 err_q;
	logic                 prev_q;

	// clearing sweep and scan counters
	logic [AW-1:0]        clr_q;
	logic [AW-1:0]        scan_q;
	logic                 scan_vld_s1;
	logic [AW-1:0]        scan_w_s1;

	// effective size and derived limits
	logic [CNT_W-1:0]     n_w;
	logic [CNT_W-1:0]     n_m1;
	logic [AW-1:0]        last_word;
	logic                 req_err;
	logic                 accept;

	// word store ports
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [AW-1:0]        ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	// update of the addressed word
	logic                 cur_bit;
	logic                 bit_set;
	logic                 bit_clr;
	logic [WORD_BITS-1:0] bit_mask;

	scan_ctrl_t           scan_ctrl;
	logic [CNT_W-1:0]     lo_set_w, hi_set_w, lo_unset_w, hi_unset_w;

	// a bit_count above MAX_BITS is clipped to MAX_BITS
	always_comb begin
		if (32'(bit_count_q) > MAX_BITS) begin
			n_w = CNT_W'(MAX_BITS);
		end else begin
			n_w = bit_count_q;
		end
		n_m1      = n_w - 11'd1;
		last_word = AW'(n_m1 >> WORD_LSB);
		req_err   = ({1'b0, bit_index} >= n_w);
		accept    = start && (state_q == ST_IDLE);
	end

	// read data of the addressed word is valid in ST_UPDATE
	always_comb begin
		bit_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << idx_q[WORD_LSB-1:0];
		cur_bit  = err_q ? 1'b0 : ram_rdata[idx_q[WORD_LSB-1:0]];
		bit_set  = 1'b0;
		bit_clr  = 1'b0;
		if (!err_q) begin
			case (req_q)
				REQ_SET:   bit_set = !cur_bit;
				REQ_CLEAR: bit_clr = cur_bit;
				default:   ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == AW'(WORD_COUNT - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_d = (n_w == '0) ? ST_DONE : ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_q == last_word) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_DONE;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
		// a size write rebuilds the map from scratch
		if (cfg_wr_en) state_d = ST_CLEAR;
	end

	// outputs of the sequencer
	always_comb begin
		ram_we         = 1'b0;
		ram_waddr      = clr_q;
		ram_wdata      = '0;
		ram_raddr      = scan_q;
		scan_ctrl.clr  = 1'b0;
		scan_ctrl.en   = scan_vld_s1;
		scan_ctrl.last = (scan_w_s1 == last_word);
		scan_ctrl.rem  = n_w[WORD_LSB-1:0];
		busy           = 1'b1;
		done           = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_IDLE: begin
				busy      = 1'b0;
				ram_raddr = AW'(bit_index >> WORD_LSB);
			end
			ST_UPDATE: begin
				ram_we        = bit_set || bit_clr;
				ram_waddr     = AW'(idx_q >> WORD_LSB);
				ram_wdata     = bit_set ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
				scan_ctrl.clr = 1'b1;
			end
			ST_DONE: begin
				done = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			bit_count_q <= BIT_COUNT_RST;
			set_total_q <= '0;
			clr_q       <= '0;
			scan_q      <= '0;
			scan_vld_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			scan_vld_s1 <= (state_q == ST_SCAN);
			if (cfg_wr_en) begin
				bit_count_q <= cfg_wr_data;
				set_total_q <= '0;
				clr_q       <= '0;
			end else begin
				if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
				if (state_q == ST_UPDATE) begin
					if (bit_set) set_total_q <= set_total_q + 11'd1;
					if (bit_clr) set_total_q <= set_total_q - 11'd1;
				end
			end
			if (state_q == ST_UPDATE) begin
				scan_q <= '0;
			end else if (state_q == ST_SCAN) begin
				scan_q <= scan_q + 1'b1;
			end
		end
	end

	// request payload and pipelined scan address
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_type;
			idx_q <= bit_index;
			err_q <= req_err;
		end
		if (state_q == ST_UPDATE) prev_q <= cur_bit;
		scan_w_s1 <= scan_q;
	end

	bsc_word_ram #(
		.DEPTH (WORD_COUNT),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	bsc_scan_unit #(
		.AW (AW)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (scan_ctrl),
		.word     (ram_rdata),
		.word_idx (scan_w_s1),
		.lo_set   (lo_set_w),
		.hi_set   (hi_set_w),
		.lo_unset (lo_unset_w),
		.hi_unset (hi_unset_w)
	);

	assign previous_bit   = prev_q;
	assign index_error    = err_q;
	assign ones_count     = set_total_q;
	assign all_zero       = (set_total_q == '0);
	assign all_one        = (set_total_q == n_w);
	assign smallest_set   = lo_set_w;
	assign biggest_set    = hi_set_w;
	assign smallest_unset = lo_unset_w;
	assign biggest_unset  = hi_unset_w;

	// a result only follows the end of a scan, or the update when the bit count is zero
	a_done_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == ST_DRAIN || $past(state_q) == ST_UPDATE))
		else $error("result strobe without a finished scan");

	// at each result, the running count does not exceed the bits in use
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (set_total_q <= n_w))
		else $error("ones count above bit count");

	// an empty map must show no set bit in the scan results
	a_zero_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(done && all_zero) |-> (lo_set_w == NONE_IDX && hi_set_w == NONE_IDX))
		else $error("scan found a set bit in an empty map");

	// an erroneous request must leave the store untouched
	a_err_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && err_q) |-> !ram_we)
		else $error("store written on an out-of-range request");

endmodule
